### sv/cru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cru_pkg
// Shared widths, codes and controller interface types of the capability
// restrict cache.
// ----------------------------------------------------------------------------
package cru_pkg;

   // default store depth
   localparam int CACHE_ENTRIES_DEF = 16;

   // field widths
   localparam int PORT_W   = 48;
   localparam int OBJ_W    = 24;
   localparam int RIGHTS_W = 8;
   localparam int RANDOM_W = 48;
   localparam int MASK_W   = 8;
   localparam int CHECK_W  = 48;
   localparam int STATUS_W = 2;

   // stored entry: port, object, rights, random, reduced mask, check (low bit up)
   localparam int MATCH_W = PORT_W + OBJ_W + RIGHTS_W + RANDOM_W + MASK_W;
   localparam int ENTRY_W = MATCH_W + CHECK_W;

   // stream payload widths
   localparam int REQ_DATA_W = ENTRY_W;
   localparam int RSP_DATA_W = RIGHTS_W + CHECK_W;

   // reset value of the all-rights register
   localparam logic [RIGHTS_W-1:0] ALL_RIGHTS_RESET = 8'hFF;

   // command codes
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_FILL   = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_TRIVIAL = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HIT     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_STORED  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load;        // latch the accepted word
      logic scan_clear;  // reset search results
      logic scan_rd;     // issue a search read
      logic upd_setup;   // latch target slot, write entry on fill
      logic upd_rd;      // issue an age update read
      logic out_load;    // load the result register
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_fill;
      logic trivial;
      logic hit;
      logic out_free;
   } ctl_status_type;

endpackage

### sv/capability_restrict_lru_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capability_restrict_lru_cache_unit
// Fully associative LRU cache of rights-restricted capabilities.
// ----------------------------------------------------------------------------
// One word is taken at a time and answered with one result word. A lookup whose
// reduced mask removes no rights skips both sweeps. A lookup that misses makes
// the search sweep only; a hit or a fill makes a search sweep and then an age
// update sweep, over the entry and age memories, one entry per cycle. The store
// comes out of reset with every entry invalid and needs no clearing pass. The
// result register lets the next word be accepted while a result still waits to
// be taken.
// ----------------------------------------------------------------------------
module capability_restrict_lru_cache_unit #(
   parameter int CACHE_ENTRIES = cru_pkg::CACHE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // server_port, object_number, cap_rights, cap_random, rights_mask, fill_check
   input  logic [cru_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd
   input  logic [0:0]                      req_tuser,
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // result_rights, result_check
   output logic [cru_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status
   output logic [cru_pkg::STATUS_W-1:0]    rsp_tuser,
   // all_rights_mask register
   input  logic                            csr_we,
   input  logic [cru_pkg::RIGHTS_W-1:0]    csr_wdata
);

   cru_pkg::ctl_cmd_type             cmd;
   cru_pkg::ctl_status_type          status;
   logic [$clog2(CACHE_ENTRIES)-1:0] rd_addr;

   // sequencer
   cru_ctl #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   // datapath
   cru_dp #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .status     (status)
   );

endmodule

### sv/cru_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cru_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/cru_ctl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cru_ctl
// Sequencer of the capability restrict cache: accept, search sweep,
// age update sweep and result hand-off.
// ----------------------------------------------------------------------------
module cru_ctl #(
   parameter int CACHE_ENTRIES = cru_pkg::CACHE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  cru_pkg::ctl_status_type          status,
   output cru_pkg::ctl_cmd_type             cmd,
   output logic [$clog2(CACHE_ENTRIES)-1:0] rd_addr
);

   localparam int IW = $clog2(CACHE_ENTRIES);
   localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PREP   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_SDRAIN = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_UPD    = 3'd5;
   localparam logic [2:0] ST_UDRAIN = 3'd6;
   localparam logic [2:0] ST_FINISH = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.scan_clear = 1'b1;
            cnt_in         = '0;
            if (status.is_fill || !status.trivial) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_SDRAIN;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         ST_SDRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.is_fill || status.hit) begin
               cmd.upd_setup = 1'b1;
               state_in      = ST_UPD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_UPD: begin
            cmd.upd_rd = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_UDRAIN;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         ST_UDRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr = cnt_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### sv/cru_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cru_dp
// Datapath of the capability restrict cache: item and config registers,
// entry and age memories, search compare, age update and result register.
// ----------------------------------------------------------------------------
module cru_dp #(
   parameter int CACHE_ENTRIES = cru_pkg::CACHE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cru_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cru_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [cru_pkg::STATUS_W-1:0]      rsp_tuser,
   input  logic                              csr_we,
   input  logic [cru_pkg::RIGHTS_W-1:0]      csr_wdata,
   input  cru_pkg::ctl_cmd_type              cmd,
   input  logic [$clog2(CACHE_ENTRIES)-1:0]  rd_addr,
   output cru_pkg::ctl_status_type           status
);

   localparam int IW = $clog2(CACHE_ENTRIES);
   localparam int AW = $clog2(CACHE_ENTRIES);
   localparam int CW = $clog2(CACHE_ENTRIES + 1);

   // field offsets inside a word and an entry
   localparam int OBJ_LO  = cru_pkg::PORT_W;
   localparam int RGT_LO  = OBJ_LO + cru_pkg::OBJ_W;
   localparam int RND_LO  = RGT_LO + cru_pkg::RIGHTS_W;
   localparam int MSK_LO  = RND_LO + cru_pkg::RANDOM_W;
   localparam int CHK_LO  = MSK_LO + cru_pkg::MASK_W;

   // item registers
   logic                            cmd_ff;
   logic [cru_pkg::PORT_W-1:0]      port_ff;
   logic [cru_pkg::OBJ_W-1:0]       obj_ff;
   logic [cru_pkg::RIGHTS_W-1:0]    rights_ff;
   logic [cru_pkg::RANDOM_W-1:0]    random_ff;
   logic [cru_pkg::MASK_W-1:0]      mask_ff;
   logic [cru_pkg::CHECK_W-1:0]     fchk_ff;
   logic [cru_pkg::RIGHTS_W-1:0]    arm_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff    <= req_tuser[0];
         port_ff   <= req_tdata[OBJ_LO-1:0];
         obj_ff    <= req_tdata[RGT_LO-1:OBJ_LO];
         rights_ff <= req_tdata[RND_LO-1:RGT_LO];
         random_ff <= req_tdata[MSK_LO-1:RND_LO];
         mask_ff   <= req_tdata[CHK_LO-1:MSK_LO];
         fchk_ff   <= req_tdata[cru_pkg::ENTRY_W-1:CHK_LO];
      end
   end

   // all-rights register
   always_ff @(posedge clock) begin
      if (reset) begin
         arm_ff <= cru_pkg::ALL_RIGHTS_RESET;
      end else if (csr_we) begin
         arm_ff <= csr_wdata;
      end
   end

   // rights reduction
   logic [cru_pkg::RIGHTS_W-1:0] own;
   logic [cru_pkg::MASK_W-1:0]   red;
   logic                         is_fill;
   logic                         trivial;

   assign own     = rights_ff & arm_ff;
   assign red     = mask_ff & own;
   assign is_fill = (cmd_ff == cru_pkg::CMD_FILL);
   assign trivial = (red == own);

   // memories
   logic                         key_we;
   logic [IW-1:0]                key_waddr;
   logic [cru_pkg::ENTRY_W-1:0]  key_wdata;
   logic [cru_pkg::ENTRY_W-1:0]  key_rdata;
   logic                         age_we;
   logic [IW-1:0]                age_waddr;
   logic [AW-1:0]                age_wdata;
   logic [AW-1:0]                age_rdata;

   cru_ram #(
      .WIDTH (cru_pkg::ENTRY_W),
      .DEPTH (CACHE_ENTRIES)
   ) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (key_wdata),
      .raddr (rd_addr),
      .rdata (key_rdata)
   );

   cru_ram #(
      .WIDTH (AW),
      .DEPTH (CACHE_ENTRIES)
   ) u_age_ram (
      .clock (clock),
      .we    (age_we),
      .waddr (age_waddr),
      .wdata (age_wdata),
      .raddr (rd_addr),
      .rdata (age_rdata)
   );

   // read stage tracking
   logic          rd_vld_ff;
   logic          wb_vld_ff;
   logic [IW-1:0] stg_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         wb_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_rd;
         wb_vld_ff <= cmd.upd_rd;
      end
   end

   always_ff @(posedge clock) begin
      stg_idx_ff <= rd_addr;
   end

   // valid bits
   logic [CACHE_ENTRIES-1:0] valid_ff;
   logic                     cur_valid;

   assign cur_valid = valid_ff[stg_idx_ff];

   // search results
   logic                         hit_ff;
   logic [AW-1:0]                best_ff;
   logic [IW-1:0]                hit_idx_ff;
   logic [cru_pkg::CHECK_W-1:0]  hit_check_ff;
   logic                         free_found_ff;
   logic [IW-1:0]                free_idx_ff;
   logic [CW-1:0]                count_ff;
   logic [AW-1:0]                old_best_ff;
   logic [IW-1:0]                old_idx_ff;
   logic                         key_match;

   assign key_match = (key_rdata[cru_pkg::MATCH_W-1:0] ==
                       {red, random_ff, rights_ff, obj_ff, port_ff});

   // search compare: youngest match, first free slot, oldest entry
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (cmd.scan_clear) begin
         hit_ff <= 1'b0;
      end else if (rd_vld_ff && !is_fill && cur_valid && key_match &&
                   (!hit_ff || age_rdata < best_ff)) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_clear) begin
         free_found_ff <= 1'b0;
         count_ff      <= '0;
         old_best_ff   <= '0;
         old_idx_ff    <= '0;
      end else if (rd_vld_ff) begin
         if (!is_fill && cur_valid && key_match &&
             (!hit_ff || age_rdata < best_ff)) begin
            best_ff      <= age_rdata;
            hit_idx_ff   <= stg_idx_ff;
            hit_check_ff <= key_rdata[cru_pkg::ENTRY_W-1:CHK_LO];
         end
         if (cur_valid) begin
            count_ff <= count_ff + CW'(1);
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= stg_idx_ff;
         end
         if (age_rdata >= old_best_ff) begin
            old_best_ff <= age_rdata;
            old_idx_ff  <= stg_idx_ff;
         end
      end
   end

   // target slot and age limit
   logic [IW-1:0] slot;
   logic [CW-1:0] limit;
   logic [IW-1:0] k_ff;
   logic [CW-1:0] limit_ff;

   always_comb begin
      if (!is_fill) begin
         slot  = hit_idx_ff;
         limit = CW'(best_ff);
      end else if (free_found_ff) begin
         slot  = free_idx_ff;
         limit = count_ff;
      end else begin
         slot  = old_idx_ff;
         limit = CW'(old_best_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd_setup) begin
         k_ff     <= slot;
         limit_ff <= limit;
      end
   end

   // entry write on fill
   assign key_we    = cmd.upd_setup && is_fill;
   assign key_waddr = slot;
   assign key_wdata = {fchk_ff, red, random_ff, rights_ff, obj_ff, port_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (key_we) begin
         valid_ff[slot] <= 1'b1;
      end
   end

   // age write-back: target becomes youngest, younger ones age by one
   assign age_we    = wb_vld_ff;
   assign age_waddr = stg_idx_ff;

   always_comb begin
      if (stg_idx_ff == k_ff) begin
         age_wdata = '0;
      end else if (cur_valid && (CW'(age_rdata) < limit_ff)) begin
         age_wdata = age_rdata + AW'(1);
      end else begin
         age_wdata = age_rdata;
      end
   end

   // result register
   logic                          rsp_valid_ff;
   logic [cru_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [cru_pkg::RIGHTS_W-1:0]  rsp_rights_ff;
   logic [cru_pkg::CHECK_W-1:0]   rsp_check_ff;
   logic [cru_pkg::STATUS_W-1:0]  status_code;
   logic [cru_pkg::RIGHTS_W-1:0]  res_rights;
   logic [cru_pkg::CHECK_W-1:0]   res_check;
   logic                          out_free;

   always_comb begin
      res_rights = red;
      res_check  = '0;
      if (is_fill) begin
         status_code = cru_pkg::STATUS_STORED;
      end else if (trivial) begin
         status_code = cru_pkg::STATUS_TRIVIAL;
         res_rights  = rights_ff;
         res_check   = random_ff;
      end else if (hit_ff) begin
         status_code = cru_pkg::STATUS_HIT;
         res_check   = hit_check_ff;
      end else begin
         status_code = cru_pkg::STATUS_MISS;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= status_code;
         rsp_rights_ff <= res_rights;
         rsp_check_ff  <= res_check;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_check_ff, rsp_rights_ff};
   assign rsp_tuser  = rsp_status_ff;

   // status to controller
   assign status.is_fill  = is_fill;
   assign status.trivial  = trivial;
   assign status.hit      = hit_ff;
   assign status.out_free = out_free;

   // checks
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load))
      else $error("result valid rose without a result load");

   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> valid_ff[hit_idx_ff])
      else $error("recorded hit points at an invalid entry");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      key_we |-> !rd_vld_ff)
      else $error("entry write overlaps a search read");

   a_upd_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_rd |-> !rd_vld_ff && !cmd.scan_rd)
      else $error("age update overlaps the search sweep");

endmodule
